>>> rtl/core/fuzzy_pid_controller_macros.svh
// Assertion macros used by the checker of the fuzzy PID controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FUZZY_PID_CONTROLLER_MACROS_SVH
`define FUZZY_PID_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fpid_pkg.sv
package fpid_pkg;

    localparam int GRID_POINTS = 101;
    localparam int GRID_SPAN   = GRID_POINTS - 1;
    localparam int GRID_IDX_W  = $clog2(GRID_POINTS);
    localparam int TERMS       = 5;

    // Accumulator widths follow from the number of grid points.
    localparam int NUM_W = GRID_IDX_W + 35;
    localparam int DEN_W = GRID_IDX_W + 18;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [31:0] Q_ONE      = 32'sd65536;
    localparam logic signed [31:0] PD_OUT_MIN = -32'sd65536;
    localparam logic signed [31:0] PD_OUT_MAX = 32'sd65536;

    localparam logic signed [19:0] G_ONE  = 20'sd65536;
    localparam logic signed [19:0] G_HALF = 20'sd32768;

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_RESET = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_ERROR_GAIN    = 3'd0,
        REG_RATE_GAIN     = 3'd1,
        REG_OUTPUT_SCALE  = 3'd2,
        REG_INTEGRAL_GAIN = 3'd3,
        REG_WINDUP_GAIN   = 3'd4,
        REG_OUT_MIN       = 3'd5,
        REG_OUT_MAX       = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        TERM_NL = 3'd0,
        TERM_NS = 3'd1,
        TERM_ZE = 3'd2,
        TERM_PS = 3'd3,
        TERM_PL = 3'd4
    } term_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef logic signed [17:0] grid_row_t [GRID_POINTS];

    localparam term_t RULE_TABLE [TERMS][TERMS] = '{
        '{TERM_NL, TERM_NL, TERM_NL, TERM_NS, TERM_ZE},
        '{TERM_NL, TERM_NL, TERM_NS, TERM_ZE, TERM_PS},
        '{TERM_NL, TERM_NS, TERM_ZE, TERM_PS, TERM_PL},
        '{TERM_NS, TERM_ZE, TERM_PS, TERM_PL, TERM_PL},
        '{TERM_ZE, TERM_PS, TERM_PL, TERM_PL, TERM_PL}
    };

    // Grid abscissae from -1 to 1, rounded to nearest with ties upward.
    function automatic grid_row_t make_grid();
        grid_row_t g;
        longint    v;
        for (int k = 0; k < GRID_POINTS; k++)
        begin
            v = (longint'(131072) * longint'(k) + longint'(GRID_SPAN / 2)) / GRID_SPAN;
            g[k] = 18'(v - 65536);
        end
        return g;
    endfunction

    localparam grid_row_t GRID_X = make_grid();

    function automatic logic [16:0] term_grade(input term_t t, input logic signed [17:0] x);
        logic signed [19:0] xe;
        logic signed [19:0] g;
        xe = 20'(x);
        g  = '0;
        case (t)
            TERM_NL:
            begin
                if (xe <= -G_ONE) g = G_ONE;
                else if (xe >= -G_HALF) g = '0;
                else g = (-G_HALF - xe) <<< 1;
            end
            TERM_NS:
            begin
                if (xe <= -G_ONE || xe >= 20'sd0) g = '0;
                else if (xe <= -G_HALF) g = (xe + G_ONE) <<< 1;
                else g = (-xe) <<< 1;
            end
            TERM_ZE:
            begin
                if (xe <= -G_HALF || xe >= G_HALF) g = '0;
                else if (xe <= 20'sd0) g = (xe + G_HALF) <<< 1;
                else g = (G_HALF - xe) <<< 1;
            end
            TERM_PS:
            begin
                if (xe <= 20'sd0 || xe >= G_ONE) g = '0;
                else if (xe <= G_HALF) g = xe <<< 1;
                else g = (G_ONE - xe) <<< 1;
            end
            default:
            begin
                if (xe <= G_HALF) g = '0;
                else if (xe >= G_ONE) g = G_ONE;
                else g = (xe - G_HALF) <<< 1;
            end
        endcase
        return g[16:0];
    endfunction

endpackage

>>> rtl/core/fpid_div.sv
module fpid_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fpid_pkg::NUM_W-1:0]   dividend,
    input  logic [fpid_pkg::DEN_W-1:0]   divisor,
    output logic [fpid_pkg::NUM_W-1:0]   quotient,
    output fpid_pkg::div_status_t        status
);

    localparam int CNT_W = $clog2(fpid_pkg::NUM_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [fpid_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [fpid_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [fpid_pkg::DEN_W-1:0]  dvs_reg, dvs_next;

    always_comb
    begin
        logic [fpid_pkg::DEN_W:0] shifted;
        logic [fpid_pkg::DEN_W:0] trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[fpid_pkg::NUM_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // One restoring step per cycle, most significant bit first.
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[fpid_pkg::DEN_W-1:0];
                quo_next = {quo_reg[fpid_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[fpid_pkg::DEN_W-1:0];
                quo_next = {quo_reg[fpid_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(fpid_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/core/fuzzy_pid_controller.sv
// Sequencing: a control step runs EN, DN, RULE, GRID, DIVS, DIV, PD, KI, SAT, WHI, WLO and DONE;
// an initialise ends after PD, and reset-state and unused words go straight to DONE. All products
// use one shared 34x34 multiplier, once per rule and per grid point, then the divider.
// Flow: one word at a time; the next word can be taken in the cycle a result is raised, and
// a result that is not taken holds the sequencer back.
// Reset: rst_n clears the sequencer, output valid and the controller state, and sets the gains and limits to defaults.
module fuzzy_pid_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] error_value,
    input  logic signed [31:0] target_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] drive_value,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int NW = fpid_pkg::NUM_W;
    localparam int DW = fpid_pkg::DEN_W;
    localparam int PW = fpid_pkg::PROD_W;
    localparam int MW = fpid_pkg::MUL_W;
    localparam int KW = fpid_pkg::GRID_IDX_W;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_EN   = 13'b0000000000010,
        S_DN   = 13'b0000000000100,
        S_RULE = 13'b0000000001000,
        S_GRID = 13'b0000000010000,
        S_DIVS = 13'b0000000100000,
        S_DIV  = 13'b0000001000000,
        S_PD   = 13'b0000010000000,
        S_KI   = 13'b0000100000000,
        S_SAT  = 13'b0001000000000,
        S_WHI  = 13'b0010000000000,
        S_WLO  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } state_t;

    localparam logic signed [PW-1:0] I32_MAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] I32_MIN = PW'(-64'sd2147483648);

    function automatic logic signed [17:0] clamp_unit(input logic signed [PW-1:0] v);
        logic signed [17:0] r;
        if (v > PW'(fpid_pkg::Q_ONE)) r = 18'(fpid_pkg::Q_ONE);
        else if (v < -PW'(fpid_pkg::Q_ONE)) r = -18'(fpid_pkg::Q_ONE);
        else r = v[17:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (v > I32_MAX) r = I32_MAX[31:0];
        else if (v < I32_MIN) r = I32_MIN[31:0];
        else r = v[31:0];
        return r;
    endfunction

    state_t                 state_reg, state_next;
    logic                   phase_reg, phase_next;
    fpid_pkg::op_t          op_reg, op_next;
    logic signed [31:0]     err_reg, err_next;
    logic signed [31:0]     tgt_reg, tgt_next;
    logic signed [31:0]     prev_reg, prev_next;
    logic signed [31:0]     integ_reg, integ_next;
    logic signed [17:0]     en_reg, en_next;
    logic signed [17:0]     dn_reg, dn_next;
    logic [16:0]            strength_reg [fpid_pkg::TERMS];
    logic [16:0]            strength_next [fpid_pkg::TERMS];
    logic [2:0]             ri_reg, ri_next;
    logic [2:0]             rj_reg, rj_next;
    logic [KW-1:0]          k_reg, k_next;
    logic signed [NW-1:0]   num_reg, num_next;
    logic [DW-1:0]          den_reg, den_next;
    logic signed [17:0]     un_reg, un_next;
    logic signed [31:0]     pd_reg, pd_next;
    logic signed [47:0]     ki_reg, ki_next;
    logic signed [31:0]     sat_reg, sat_next;
    logic signed [MW-1:0]   hi_reg, hi_next;
    logic [15:0]            lo_reg, lo_next;
    logic signed [PW-1:0]   acc_reg, acc_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [31:0]     result_reg, result_next;
    logic signed [31:0]     out_data_reg, out_data_next;
    logic                   out_valid_reg, out_valid_next;
    logic [30:0]            error_gain_reg, error_gain_next;
    logic [30:0]            rate_gain_reg, rate_gain_next;
    logic [30:0]            output_scale_reg, output_scale_next;
    logic signed [31:0]     integral_gain_reg, integral_gain_next;
    logic signed [31:0]     windup_gain_reg, windup_gain_next;
    logic signed [31:0]     out_min_reg, out_min_next;
    logic signed [31:0]     out_max_reg, out_max_next;

    logic signed [MW-1:0]   mul_a, mul_b;
    logic [16:0]            agg;
    logic                   div_start;
    logic [NW-1:0]          div_dividend;
    logic [NW-1:0]          div_quotient;
    fpid_pkg::div_status_t  div_st;

    fpid_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .quotient (div_quotient),
        .status   (div_st)
    );

    // Aggregated output membership at the current grid point.
    always_comb
    begin
        logic [16:0] g;
        logic [16:0] c;
        agg = '0;
        for (int i = 0; i < fpid_pkg::TERMS; i++)
        begin
            g = fpid_pkg::term_grade(fpid_pkg::term_t'(i), fpid_pkg::GRID_X[k_reg]);
            c = (strength_reg[i] < g) ? strength_reg[i] : g;
            if (c > agg) agg = c;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_EN:
            begin
                mul_a = MW'(err_reg);
                mul_b = {3'b0, error_gain_reg};
            end
            S_DN:
            begin
                if (op_reg == fpid_pkg::OP_INIT) mul_a = MW'(err_reg);
                else mul_a = MW'(err_reg) - MW'(prev_reg);
                mul_b = {3'b0, rate_gain_reg};
            end
            S_RULE:
            begin
                mul_a = {17'b0, fpid_pkg::term_grade(fpid_pkg::term_t'(ri_reg), en_reg)};
                mul_b = {17'b0, fpid_pkg::term_grade(fpid_pkg::term_t'(rj_reg), dn_reg)};
            end
            S_GRID:
            begin
                mul_a = MW'(fpid_pkg::GRID_X[k_reg]);
                mul_b = {17'b0, agg};
            end
            S_PD:
            begin
                mul_a = MW'(un_reg);
                mul_b = {3'b0, output_scale_reg};
            end
            S_KI:
            begin
                mul_a = MW'(err_reg);
                mul_b = MW'(integral_gain_reg);
            end
            S_WHI:
            begin
                mul_a = hi_reg;
                mul_b = MW'(windup_gain_reg);
            end
            S_WLO:
            begin
                mul_a = {18'b0, lo_reg};
                mul_b = MW'(windup_gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    assign div_dividend = ((num_reg < 0) ? NW'(-num_reg) : NW'(num_reg))
                        + NW'(den_reg >> 1);

    always_comb
    begin
        logic [16:0]          w;
        fpid_pkg::term_t      c;
        logic [NW-1:0]        q;
        logic signed [PW-1:0] v;
        logic signed [49:0]   unsat;
        logic signed [49:0]   s;
        logic signed [49:0]   d;
        logic signed [PW-1:0] acc2;

        state_next    = state_reg;
        phase_next    = 1'b0;
        op_next       = op_reg;
        err_next      = err_reg;
        tgt_next      = tgt_reg;
        prev_next     = prev_reg;
        integ_next    = integ_reg;
        en_next       = en_reg;
        dn_next       = dn_reg;
        strength_next = strength_reg;
        ri_next       = ri_reg;
        rj_next       = rj_reg;
        k_next        = k_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        un_next       = un_reg;
        pd_next       = pd_reg;
        ki_next       = ki_reg;
        sat_next      = sat_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        acc_next      = acc_reg;
        result_next   = result_reg;
        out_data_next = out_data_reg;
        div_start     = 1'b0;

        w     = prod_reg[32:16];
        c     = fpid_pkg::RULE_TABLE[ri_reg][rj_reg];
        q     = div_quotient;
        v     = prod_reg >>> 16;
        unsat = 50'(pd_reg) + 50'(integ_reg) + 50'(ki_reg);
        s     = unsat;
        if (s < 50'(out_min_reg)) s = 50'(out_min_reg);
        if (s > 50'(out_max_reg)) s = 50'(out_max_reg);
        d     = s - unsat;
        acc2  = acc_reg + v;

        out_valid_next = out_valid_reg && !out_ready;

        error_gain_next    = error_gain_reg;
        rate_gain_next     = rate_gain_reg;
        output_scale_next  = output_scale_reg;
        integral_gain_next = integral_gain_reg;
        windup_gain_next   = windup_gain_reg;
        out_min_next       = out_min_reg;
        out_max_next       = out_max_reg;
        if (cfg_we)
        begin
            case (fpid_pkg::reg_idx_t'(cfg_index))
                fpid_pkg::REG_ERROR_GAIN:    error_gain_next    = cfg_data[30:0];
                fpid_pkg::REG_RATE_GAIN:     rate_gain_next     = cfg_data[30:0];
                fpid_pkg::REG_OUTPUT_SCALE:  output_scale_next  = cfg_data[30:0];
                fpid_pkg::REG_INTEGRAL_GAIN: integral_gain_next = cfg_data;
                fpid_pkg::REG_WINDUP_GAIN:   windup_gain_next   = cfg_data;
                fpid_pkg::REG_OUT_MIN:       out_min_next       = cfg_data;
                fpid_pkg::REG_OUT_MAX:       out_max_next       = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = fpid_pkg::op_t'(operation);
                    err_next = error_value;
                    tgt_next = target_value;
                    case (fpid_pkg::op_t'(operation))
                        fpid_pkg::OP_STEP,
                        fpid_pkg::OP_INIT:
                            state_next = S_EN;
                        fpid_pkg::OP_RESET:
                        begin
                            prev_next   = '0;
                            integ_next  = '0;
                            result_next = '0;
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            result_next = '0;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_EN:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    en_next    = clamp_unit(v);
                    state_next = S_DN;
                end
            end
            S_DN:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    dn_next = clamp_unit(v);
                    for (int i = 0; i < fpid_pkg::TERMS; i++)
                        strength_next[i] = '0;
                    ri_next    = '0;
                    rj_next    = '0;
                    state_next = S_RULE;
                end
            end
            S_RULE:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (w > strength_reg[c]) strength_next[c] = w;
                    if (rj_reg == 3'(fpid_pkg::TERMS - 1))
                    begin
                        rj_next = '0;
                        ri_next = ri_reg + 1'b1;
                        if (ri_reg == 3'(fpid_pkg::TERMS - 1))
                        begin
                            k_next     = '0;
                            num_next   = '0;
                            den_next   = '0;
                            state_next = S_GRID;
                        end
                    end
                    else
                    begin
                        rj_next = rj_reg + 1'b1;
                    end
                end
            end
            S_GRID:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    den_next = den_reg + DW'(agg);
                end
                else
                begin
                    num_next = num_reg + NW'(prod_reg);
                    k_next   = k_reg + 1'b1;
                    if (k_reg == KW'(fpid_pkg::GRID_POINTS - 1)) state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                // With no rule firing the fuzzy output is zero.
                if (den_reg == '0)
                begin
                    un_next    = '0;
                    state_next = S_PD;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_st.done && !div_st.busy)
                begin
                    if (q > NW'(fpid_pkg::Q_ONE)) q = NW'(fpid_pkg::Q_ONE);
                    un_next    = (num_reg < 0) ? -18'(q) : 18'(q);
                    state_next = S_PD;
                end
            end
            S_PD:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (v < PW'(fpid_pkg::PD_OUT_MIN)) pd_next = fpid_pkg::PD_OUT_MIN;
                    else if (v > PW'(fpid_pkg::PD_OUT_MAX)) pd_next = fpid_pkg::PD_OUT_MAX;
                    else pd_next = v[31:0];
                    if (op_reg == fpid_pkg::OP_INIT)
                    begin
                        integ_next  = sat32(PW'(tgt_reg) - PW'(pd_next));
                        prev_next   = '0;
                        result_next = tgt_reg;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_KI;
                    end
                end
            end
            S_KI:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    ki_next    = v[47:0];
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                sat_next   = s[31:0];
                hi_next    = MW'(d >>> 16);
                lo_next    = d[15:0];
                acc_next   = PW'(integ_reg) + PW'(ki_reg);
                state_next = S_WHI;
            end
            S_WHI:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    acc_next   = acc_reg + prod_reg;
                    state_next = S_WLO;
                end
            end
            S_WLO:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    integ_next  = sat32(acc2);
                    prev_next   = err_reg;
                    result_next = sat_reg;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            phase_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            prev_reg          <= '0;
            integ_reg         <= '0;
            error_gain_reg    <= 31'(fpid_pkg::Q_ONE);
            rate_gain_reg     <= 31'(fpid_pkg::Q_ONE);
            output_scale_reg  <= 31'(fpid_pkg::Q_ONE);
            integral_gain_reg <= '0;
            windup_gain_reg   <= '0;
            out_min_reg       <= -fpid_pkg::Q_ONE;
            out_max_reg       <= fpid_pkg::Q_ONE;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            out_valid_reg     <= out_valid_next;
            prev_reg          <= prev_next;
            integ_reg         <= integ_next;
            error_gain_reg    <= error_gain_next;
            rate_gain_reg     <= rate_gain_next;
            output_scale_reg  <= output_scale_next;
            integral_gain_reg <= integral_gain_next;
            windup_gain_reg   <= windup_gain_next;
            out_min_reg       <= out_min_next;
            out_max_reg       <= out_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        err_reg      <= err_next;
        tgt_reg      <= tgt_next;
        en_reg       <= en_next;
        dn_reg       <= dn_next;
        strength_reg <= strength_next;
        ri_reg       <= ri_next;
        rj_reg       <= rj_next;
        k_reg        <= k_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        un_reg       <= un_next;
        pd_reg       <= pd_next;
        ki_reg       <= ki_next;
        sat_reg      <= sat_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign drive_value = out_data_reg;

endmodule

>>> rtl/core/fpid_checker.sv
`include "fuzzy_pid_controller_macros.svh"

module fpid_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] drive_value
);

    // A result word that is not taken stays offered unchanged.
    `FPID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
    `FPID_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(drive_value), "result changed")

    // The controller works on one word at a time.
    `FPID_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")

    // A new result appears only as the sequencer returns to waiting for input.
    `FPID_ASSERT_NOW(a_result_when_idle, $rose(out_valid), in_ready, "result raised while busy")

endmodule

bind fuzzy_pid_controller fpid_checker u_fpid_checker (.*);
